// ===== rtl/sfrq_pkg.sv =====
// Shared types and constants for the shortest-first request queue.
// Used by sfrq_ctrl, sfrq_dp and shortest_first_request_queue_core.
package sfrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 16;
  localparam int ID_BITS_DEF     = 16;

  // fixed port field widths
  localparam int DUR_BITS  = 16;
  localparam int PID_BITS  = 16;
  localparam int FILL_BITS = 5;
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 40;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SERVE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS_CMP,
    S_INS_PUT,
    S_SRV_HEAD,
    S_SRV_SHIFT,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    RA_ZERO,
    RA_CUR,
    RA_CUR_M1,
    RA_CUR_M2,
    RA_CUR_P1
  } rd_sel_t;

  typedef enum logic {
    WA_CUR,
    WA_CUR_M1
  } wr_sel_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ONE,
    CUR_DEC,
    CUR_INC
  } cur_op_t;

  typedef struct packed {
    logic    take;       // latch the accepted transaction, cursor <= count
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    wr_item;    // 1: write the new request, 0: move the entry just read
    cur_op_t cur_op;
    logic    head;       // capture the entry just read as the served request
    logic    set_status;
    status_t status;
    logic    commit;     // load the result register and update the count
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic cur_zero;
    logic cur_one;
    logic greater;       // entry just read has a longer duration than the new one
    logic more;          // cursor < count
    logic more_next;     // cursor + 1 < count
    logic out_free;
  } flags_t;

endpackage

// ===== rtl/sfrq_ctrl.sv =====
// Sequencer for the shortest-first request queue.
// Depends on sfrq_pkg; drives the command bundle of sfrq_dp.
module sfrq_ctrl import sfrq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  flags_t flags,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = RA_ZERO;
    cmd.wr_sel     = WA_CUR;
    cmd.cur_op     = CUR_HOLD;
    cmd.status     = ST_INSERTED;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.set_status = 1'b1;
        if (flags.op == OP_INSERT) begin
          if (flags.full) begin
            cmd.status = ST_FULL;
            state_next = S_FIN;
          end else if (flags.cur_zero) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_item = 1'b1;
            cmd.status  = ST_INSERTED;
            state_next  = S_FIN;
          end else begin
            cmd.set_status = 1'b0;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RA_CUR_M1;
            state_next     = S_INS_CMP;
          end
        end else begin
          if (flags.empty) begin
            cmd.status = ST_EMPTY;
            state_next = S_FIN;
          end else begin
            cmd.set_status = 1'b0;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RA_ZERO;
            cmd.cur_op     = CUR_ONE;
            state_next     = S_SRV_HEAD;
          end
        end
      end
      // walk down from the tail, moving longer entries up by one
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (flags.greater) begin
          cmd.cur_op = CUR_DEC;
          if (flags.cur_one) begin
            state_next = S_INS_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_CUR_M2;
          end
        end else begin
          // equal keys stay ahead: first in, first out
          cmd.wr_item    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_INSERTED;
          state_next     = S_FIN;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_item    = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ST_INSERTED;
        state_next     = S_FIN;
      end
      S_SRV_HEAD: begin
        cmd.head       = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ST_SERVED;
        if (flags.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_CUR;
          state_next = S_SRV_SHIFT;
        end else begin
          state_next = S_FIN;
        end
      end
      // close the gap left by the served head
      S_SRV_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_CUR_M1;
        if (flags.more_next) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_CUR_P1;
          cmd.cur_op = CUR_INC;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (flags.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sfrq_dp.sv =====
// Datapath of the shortest-first request queue: request memory, cursor,
// fill count and result register. Depends on sfrq_pkg; commanded by sfrq_ctrl.
module sfrq_dp import sfrq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  input  logic [0:0]               s_tuser,
  input  cmd_t                     cmd,
  output flags_t                   flags,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  output logic [1:0]               m_tuser
);

  localparam int KW    = (KEY_BITS < DUR_BITS) ? KEY_BITS : DUR_BITS;
  localparam int IW    = (ID_BITS < PID_BITS) ? ID_BITS : PID_BITS;
  localparam int EW    = KW + IW;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [EW-1:0]    mem [QUEUE_DEPTH];
  logic [EW-1:0]    rd_data;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] cursor;
  op_t              item_op;
  logic [KW-1:0]    item_key;
  logic [IW-1:0]    item_id;
  status_t          status;
  logic [KW-1:0]    srv_key;
  logic [IW-1:0]    srv_id;

  logic [CNT_W-1:0] rd_full, wr_full;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [EW-1:0]    wr_data;

  status_t             out_status;
  logic [PID_BITS-1:0] out_pid;
  logic [DUR_BITS-1:0] out_dur;
  logic [FILL_BITS-1:0] out_fill;

  always_comb begin
    unique case (cmd.rd_sel)
      RA_ZERO:   rd_full = '0;
      RA_CUR:    rd_full = cursor;
      RA_CUR_M1: rd_full = cursor - CNT_W'(1);
      RA_CUR_M2: rd_full = cursor - CNT_W'(2);
      RA_CUR_P1: rd_full = cursor + CNT_W'(1);
      default:   rd_full = '0;
    endcase
    unique case (cmd.wr_sel)
      WA_CUR:    wr_full = cursor;
      WA_CUR_M1: wr_full = cursor - CNT_W'(1);
      default:   wr_full = cursor;
    endcase
  end

  assign rd_addr = rd_full[IDX_W-1:0];
  assign wr_addr = wr_full[IDX_W-1:0];
  assign wr_data = cmd.wr_item ? {item_key, item_id} : rd_data;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    unique case (status)
      ST_INSERTED: count_next = count + CNT_W'(1);
      ST_SERVED:   count_next = count - CNT_W'(1);
      default:     count_next = count;
    endcase
  end

  // item, cursor and served request
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_op  <= op_t'(s_tuser[0]);
      item_key <= s_tdata[KW-1:0];
      item_id  <= s_tdata[DUR_BITS+IW-1:DUR_BITS];
      cursor   <= count;
      srv_key  <= '0;
      srv_id   <= '0;
    end else begin
      unique case (cmd.cur_op)
        CUR_HOLD: cursor <= cursor;
        CUR_ONE:  cursor <= CNT_W'(1);
        CUR_DEC:  cursor <= cursor - CNT_W'(1);
        CUR_INC:  cursor <= cursor + CNT_W'(1);
        default:  cursor <= cursor;
      endcase
      if (cmd.head) begin
        srv_key <= rd_data[EW-1:IW];
        srv_id  <= rd_data[IW-1:0];
      end
    end
    if (cmd.set_status) begin
      status <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= status;
      out_pid    <= PID_BITS'(srv_id);
      out_dur    <= DUR_BITS'(srv_key);
      out_fill   <= FILL_BITS'(count_next);
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_fill, out_dur, out_pid};

  assign flags.op        = item_op;
  assign flags.full      = (count == CNT_W'(QUEUE_DEPTH));
  assign flags.empty     = (count == '0);
  assign flags.cur_zero  = (cursor == '0);
  assign flags.cur_one   = (cursor == CNT_W'(1));
  assign flags.greater   = (rd_data[EW-1:IW] > item_key);
  assign flags.more      = (cursor < count);
  assign flags.more_next = ({1'b0, cursor} + (CNT_W+1)'(1)) < {1'b0, count};
  assign flags.out_free  = !m_tvalid || m_tready;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before transfer");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same entry in one cycle");

  a_serve_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && status == ST_SERVED) |=> (count == $past(count) - CNT_W'(1)))
    else $error("serve did not reduce the fill count");
`endif

endmodule

// ===== rtl/shortest_first_request_queue_core.sv =====
// Shortest-first request queue: each transaction inserts a print request or
// serves the one with the smallest duration (ties first in, first out) and
// returns one result transaction. Full, empty and insert into an empty queue
// skip the walk; otherwise the time taken is set by the walk over the
// single-write, single-read request memory, one entry moved per cycle, over
// at most the n requests waiting. A new transaction is taken once the
// previous one has reached the result register, which holds it until the
// downstream side accepts it. Top level; depends on sfrq_pkg, sfrq_ctrl and
// sfrq_dp.
module shortest_first_request_queue_core import sfrq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // duration[15:0], process_id[31:16]
  input  logic [0:0]               s_tuser,   // operation[0]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // served_process_id[15:0],
                                              // served_duration[31:16],
                                              // fill_count[36:32], zero[39:37]
  output logic [1:0]               m_tuser    // status[1:0]
);

  cmd_t   cmd;
  flags_t flags;

  sfrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  sfrq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .flags    (flags),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
